@@ rtl/core/flash_block_table_manager_assert.svh @@
// assertion macros for the block table manager
`ifndef FLASH_BLOCK_TABLE_MANAGER_ASSERT_SVH
`define FLASH_BLOCK_TABLE_MANAGER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define FBTM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define FBTM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/fbtm_pkg.sv @@
`default_nettype none

package fbtm_pkg;

    // table sizes, settled by the fixed field widths
    localparam int LOGICAL_PAGES   = 4096;
    localparam int USER_BLOCKS     = 64;
    localparam int PAGES_PER_BLOCK = 256;

    localparam int MAP_AW   = $clog2(LOGICAL_PAGES);
    localparam int BLK_AW   = $clog2(USER_BLOCKS);
    localparam int CNT_W    = $clog2(PAGES_PER_BLOCK + 1);
    localparam int ERASE_W  = 16;
    localparam int MAP_W    = 15;
    localparam int STATE_W  = 2;

    // map entry layout
    localparam int MAP_VALID_BIT = 14;

    localparam logic [ERASE_W-1:0] ERASE_MAX = 16'hFFFF;

    // block states
    localparam logic [STATE_W-1:0] ST_CLOSED = 2'd0;
    localparam logic [STATE_W-1:0] ST_OPEN   = 2'd1;
    localparam logic [STATE_W-1:0] ST_VICTIM = 2'd2;

    // operation codes
    localparam logic [2:0] MODE_UPDATE = 3'd0;
    localparam logic [2:0] MODE_FREE   = 3'd1;
    localparam logic [2:0] MODE_VICTIM = 3'd2;
    localparam logic [2:0] MODE_OPEN   = 3'd3;
    localparam logic [2:0] MODE_SET    = 3'd4;
    localparam logic [2:0] MODE_FORMAT = 3'd5;

    // datapath command, one per cycle
    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLEAR,
        OP_CAPTURE,
        OP_MAP_RD,
        OP_MAP_CHK,
        OP_OLD_RD,
        OP_OLD_WR,
        OP_NEW_RD,
        OP_NEW_WR,
        OP_SCAN_START,
        OP_SCAN,
        OP_OPEN_RD,
        OP_OPEN_WR,
        OP_SET_WR,
        OP_FMT_WR,
        OP_RESULT
    } dp_op_t;

    // datapath status towards the controller
    typedef struct packed {
        logic [2:0] mode;
        logic       lp_ok;
        logic       busy;
        logic       tgt_ok;
        logic       clr_last;
        logic       blk_last;
    } stat_t;

endpackage

`default_nettype wire

@@ rtl/core/fbtm_ram.sv @@
`default_nettype none

module fbtm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // one write port, registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ rtl/core/fbtm_ctrl.sv @@
`default_nettype none

module fbtm_ctrl import fbtm_pkg::*; (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  wire logic  out_ready,
    input  wire stat_t stat,
    output dp_op_t     op
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_MAP_CHK,
        S_OLD_RD,
        S_OLD_WR,
        S_NEW_RD,
        S_NEW_WR,
        S_SCAN,
        S_DRAIN,
        S_OPEN_WR,
        S_FMT,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // next state and datapath command
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        op             = OP_NONE;
        case (state_reg)
            S_CLEAR:
            begin
                op = OP_CLEAR;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op         = OP_CAPTURE;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_DONE;
                case (stat.mode)
                    MODE_UPDATE:
                    begin
                        if (stat.lp_ok)
                        begin
                            op         = OP_MAP_RD;
                            state_next = S_MAP_CHK;
                        end
                    end
                    MODE_FREE, MODE_VICTIM:
                    begin
                        op         = OP_SCAN_START;
                        state_next = S_SCAN;
                    end
                    MODE_OPEN:
                    begin
                        if (stat.tgt_ok)
                        begin
                            op         = OP_OPEN_RD;
                            state_next = S_OPEN_WR;
                        end
                    end
                    MODE_SET:
                    begin
                        if (stat.tgt_ok)
                        begin
                            op = OP_SET_WR;
                        end
                    end
                    MODE_FORMAT:
                    begin
                        op         = OP_SCAN_START;
                        state_next = S_FMT;
                    end
                    default:
                    begin
                        op = OP_NONE;
                    end
                endcase
            end
            S_MAP_CHK:
            begin
                op         = OP_MAP_CHK;
                state_next = stat.busy ? S_DONE : S_OLD_RD;
            end
            S_OLD_RD:
            begin
                op         = OP_OLD_RD;
                state_next = S_OLD_WR;
            end
            S_OLD_WR:
            begin
                op         = OP_OLD_WR;
                state_next = S_NEW_RD;
            end
            S_NEW_RD:
            begin
                op         = OP_NEW_RD;
                state_next = S_NEW_WR;
            end
            S_NEW_WR:
            begin
                op         = OP_NEW_WR;
                state_next = S_DONE;
            end
            S_SCAN:
            begin
                op = OP_SCAN;
                if (stat.blk_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                // last compare lands this cycle
                state_next = S_DONE;
            end
            S_OPEN_WR:
            begin
                op         = OP_OPEN_WR;
                state_next = S_DONE;
            end
            S_FMT:
            begin
                op = OP_FMT_WR;
                if (stat.blk_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    op             = OP_RESULT;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

@@ rtl/core/fbtm_dpath.sv @@
`default_nettype none

module fbtm_dpath import fbtm_pkg::*; (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire dp_op_t       op,
    output stat_t             stat,
    input  wire logic [2:0]   mode,
    input  wire logic [11:0]  logical_page,
    input  wire logic         new_valid,
    input  wire logic [5:0]   new_block,
    input  wire logic [7:0]   new_page,
    input  wire logic         stream_kind,
    input  wire logic         journal_busy,
    input  wire logic [5:0]   target_block,
    input  wire logic [1:0]   target_state,
    input  wire logic         take_first,
    output logic              accepted,
    output logic              found,
    output logic [5:0]        found_block,
    output logic [8:0]        found_count,
    output logic              victim_hit,
    output logic              old_valid,
    output logic [5:0]        old_block,
    output logic [7:0]        old_page
);

    // captured item
    logic [2:0]  mode_reg;
    logic [11:0] lp_reg;
    logic        nvalid_reg;
    logic [5:0]  nblock_reg;
    logic [7:0]  npage_reg;
    logic        stream_reg;
    logic        busy_reg;
    logic [5:0]  tgt_block_reg;
    logic [1:0]  tgt_state_reg;
    logic        first_reg;

    // working result
    logic              acc_reg;
    logic              victim_reg;
    logic              old_valid_reg;
    logic [5:0]        old_block_reg;
    logic [7:0]        old_page_reg;
    logic              found_reg;
    logic [5:0]        fblk_reg;
    logic [CNT_W-1:0]  fcnt_reg;
    logic              skip_reg;

    // sweep counters and scan pipeline
    logic [MAP_AW-1:0] clr_idx_reg;
    logic [BLK_AW-1:0] blk_idx_reg;
    logic [BLK_AW-1:0] cmp_idx_reg;
    logic              pend_reg;

    // output register
    logic              out_accepted_reg;
    logic              out_found_reg;
    logic [5:0]        out_found_block_reg;
    logic [8:0]        out_found_count_reg;
    logic              out_victim_reg;
    logic              out_old_valid_reg;
    logic [5:0]        out_old_block_reg;
    logic [7:0]        out_old_page_reg;

    // memory ports
    logic                map_we;
    logic [MAP_AW-1:0]   map_waddr;
    logic [MAP_W-1:0]    map_wdata;
    logic [MAP_W-1:0]    map_q;
    logic                st_we;
    logic [BLK_AW-1:0]   st_waddr;
    logic [STATE_W-1:0]  st_wdata;
    logic [BLK_AW-1:0]   st_raddr;
    logic [STATE_W-1:0]  st_q;
    logic                cnt_we;
    logic [BLK_AW-1:0]   cnt_waddr;
    logic [CNT_W-1:0]    cnt_wdata;
    logic [BLK_AW-1:0]   cnt_raddr;
    logic [CNT_W-1:0]    cnt_q;
    logic                er_we;
    logic [BLK_AW-1:0]   er_waddr;
    logic [ERASE_W-1:0]  er_wdata;
    logic [ERASE_W-1:0]  er_q;

    logic                clr_blk;
    logic                ob_ok;
    logic                nb_ok;
    logic [MAP_W-1:0]    new_entry;
    logic [CNT_W-1:0]    cnt_dec;
    logic [CNT_W-1:0]    cnt_inc;
    logic [ERASE_W-1:0]  erase_inc;
    logic                free_hit;
    logic                victim_better;

    assign clr_blk   = (32'(clr_idx_reg) < USER_BLOCKS);
    assign ob_ok     = old_valid_reg && (32'(old_block_reg) < USER_BLOCKS);
    assign nb_ok     = nvalid_reg && (32'(nblock_reg) < USER_BLOCKS);
    assign new_entry = nvalid_reg ? {1'b1, nblock_reg, npage_reg} : '0;

    // saturating counter updates
    assign cnt_dec   = (cnt_q != '0) ? cnt_q - 1'b1 : cnt_q;
    assign cnt_inc   = (cnt_q < CNT_W'(PAGES_PER_BLOCK)) ? cnt_q + 1'b1 : cnt_q;
    assign erase_inc = (er_q != ERASE_MAX) ? er_q + 1'b1 : er_q;

    // scan compare on the entry read last cycle
    assign free_hit      = (st_q == ST_CLOSED) && (cnt_q == '0) && !found_reg;
    assign victim_better = (st_q == ST_CLOSED) && (cnt_q != '0) &&
                           (!found_reg || (cnt_q < fcnt_reg));

    // write and read port selection
    always_comb
    begin
        map_we    = 1'b0;
        map_waddr = lp_reg[MAP_AW-1:0];
        map_wdata = new_entry;
        st_we     = 1'b0;
        st_waddr  = tgt_block_reg[BLK_AW-1:0];
        st_wdata  = tgt_state_reg;
        st_raddr  = blk_idx_reg;
        cnt_we    = 1'b0;
        cnt_waddr = old_block_reg[BLK_AW-1:0];
        cnt_wdata = cnt_dec;
        cnt_raddr = blk_idx_reg;
        er_we     = 1'b0;
        er_waddr  = tgt_block_reg[BLK_AW-1:0];
        er_wdata  = erase_inc;
        case (op)
            OP_CLEAR:
            begin
                map_we    = 1'b1;
                map_waddr = clr_idx_reg;
                map_wdata = '0;
                st_we     = clr_blk;
                st_waddr  = clr_idx_reg[BLK_AW-1:0];
                st_wdata  = ST_CLOSED;
                cnt_we    = clr_blk;
                cnt_waddr = clr_idx_reg[BLK_AW-1:0];
                cnt_wdata = '0;
                er_we     = clr_blk;
                er_waddr  = clr_idx_reg[BLK_AW-1:0];
                er_wdata  = '0;
            end
            OP_MAP_CHK:
            begin
                map_we = !busy_reg;
            end
            OP_OLD_RD:
            begin
                st_raddr  = old_block_reg[BLK_AW-1:0];
                cnt_raddr = old_block_reg[BLK_AW-1:0];
            end
            OP_OLD_WR:
            begin
                cnt_we = ob_ok;
            end
            OP_NEW_RD:
            begin
                cnt_raddr = nblock_reg[BLK_AW-1:0];
            end
            OP_NEW_WR:
            begin
                cnt_we    = nb_ok;
                cnt_waddr = nblock_reg[BLK_AW-1:0];
                cnt_wdata = cnt_inc;
            end
            OP_OPEN_WR:
            begin
                st_we    = 1'b1;
                st_wdata = ST_OPEN;
                er_we    = 1'b1;
            end
            OP_SET_WR:
            begin
                st_we = 1'b1;
            end
            OP_FMT_WR:
            begin
                st_we     = 1'b1;
                st_waddr  = blk_idx_reg;
                st_wdata  = ST_CLOSED;
                cnt_we    = 1'b1;
                cnt_waddr = blk_idx_reg;
                cnt_wdata = '0;
            end
            default:
            begin
                map_we = 1'b0;
            end
        endcase
    end

    // page map and block tables
    fbtm_ram #(.WIDTH(MAP_W), .DEPTH(LOGICAL_PAGES)) u_map_ram (
        .clk     (clk),
        .wr_en   (map_we),
        .wr_addr (map_waddr),
        .wr_data (map_wdata),
        .rd_addr (lp_reg[MAP_AW-1:0]),
        .rd_data (map_q)
    );

    fbtm_ram #(.WIDTH(STATE_W), .DEPTH(USER_BLOCKS)) u_state_ram (
        .clk     (clk),
        .wr_en   (st_we),
        .wr_addr (st_waddr),
        .wr_data (st_wdata),
        .rd_addr (st_raddr),
        .rd_data (st_q)
    );

    fbtm_ram #(.WIDTH(CNT_W), .DEPTH(USER_BLOCKS)) u_count_ram (
        .clk     (clk),
        .wr_en   (cnt_we),
        .wr_addr (cnt_waddr),
        .wr_data (cnt_wdata),
        .rd_addr (cnt_raddr),
        .rd_data (cnt_q)
    );

    fbtm_ram #(.WIDTH(ERASE_W), .DEPTH(USER_BLOCKS)) u_erase_ram (
        .clk     (clk),
        .wr_en   (er_we),
        .wr_addr (er_waddr),
        .wr_data (er_wdata),
        .rd_addr (tgt_block_reg[BLK_AW-1:0]),
        .rd_data (er_q)
    );

    // sweep counter and scan pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_idx_reg <= '0;
            pend_reg    <= 1'b0;
        end
        else
        begin
            if (op == OP_CLEAR)
            begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
            end
            pend_reg <= (op == OP_SCAN);
        end
    end

    // item capture, search and result registers
    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= blk_idx_reg;
        case (op)
            OP_CAPTURE:
            begin
                mode_reg      <= mode;
                lp_reg        <= logical_page;
                nvalid_reg    <= new_valid;
                nblock_reg    <= new_block;
                npage_reg     <= new_page;
                stream_reg    <= stream_kind;
                busy_reg      <= journal_busy;
                tgt_block_reg <= target_block;
                tgt_state_reg <= target_state;
                first_reg     <= take_first;
                acc_reg       <= 1'b0;
                victim_reg    <= 1'b0;
                old_valid_reg <= 1'b0;
                old_block_reg <= '0;
                old_page_reg  <= '0;
                found_reg     <= 1'b0;
                fblk_reg      <= '0;
                fcnt_reg      <= '0;
            end
            OP_MAP_CHK:
            begin
                acc_reg       <= !busy_reg;
                old_valid_reg <= map_q[MAP_VALID_BIT];
                old_block_reg <= map_q[MAP_VALID_BIT] ? map_q[13:8] : 6'd0;
                old_page_reg  <= map_q[MAP_VALID_BIT] ? map_q[7:0] : 8'd0;
            end
            OP_OLD_WR:
            begin
                victim_reg <= ob_ok && !stream_reg && (st_q == ST_VICTIM);
            end
            OP_SCAN_START:
            begin
                blk_idx_reg <= '0;
                skip_reg    <= !first_reg;
            end
            OP_SCAN, OP_FMT_WR:
            begin
                blk_idx_reg <= blk_idx_reg + 1'b1;
            end
            OP_RESULT:
            begin
                out_accepted_reg    <= acc_reg;
                out_found_reg       <= found_reg;
                out_found_block_reg <= fblk_reg;
                out_found_count_reg <= 9'(fcnt_reg);
                out_victim_reg      <= victim_reg;
                out_old_valid_reg   <= old_valid_reg;
                out_old_block_reg   <= old_block_reg;
                out_old_page_reg    <= old_page_reg;
            end
            default:
            begin
            end
        endcase

        // compare the entry read in the previous scan cycle
        if (pend_reg)
        begin
            if (mode_reg == MODE_FREE)
            begin
                if (free_hit)
                begin
                    if (skip_reg)
                    begin
                        skip_reg <= 1'b0;
                    end
                    else
                    begin
                        found_reg <= 1'b1;
                        fblk_reg  <= 6'(cmp_idx_reg);
                    end
                end
            end
            else if (victim_better)
            begin
                found_reg <= 1'b1;
                fblk_reg  <= 6'(cmp_idx_reg);
                fcnt_reg  <= cnt_q;
            end
        end
    end

    // status towards the controller
    always_comb
    begin
        stat.mode     = mode_reg;
        stat.lp_ok    = (32'(lp_reg) < LOGICAL_PAGES);
        stat.busy     = busy_reg;
        stat.tgt_ok   = (32'(tgt_block_reg) < USER_BLOCKS);
        stat.clr_last = (clr_idx_reg == MAP_AW'(LOGICAL_PAGES - 1));
        stat.blk_last = (blk_idx_reg == BLK_AW'(USER_BLOCKS - 1));
    end

    assign accepted    = out_accepted_reg;
    assign found       = out_found_reg;
    assign found_block = out_found_block_reg;
    assign found_count = out_found_count_reg;
    assign victim_hit  = out_victim_reg;
    assign old_valid   = out_old_valid_reg;
    assign old_block   = out_old_block_reg;
    assign old_page    = out_old_page_reg;

endmodule

`default_nettype wire

@@ rtl/core/flash_block_table_manager.sv @@
// Flash translation block table: logical-to-physical page map (4096 entries) plus a state,
// valid-page count and erase count for each of 64 blocks. One item is worked at a time
// and gives one result item. After reset the page map is swept clear, during which no item
// is taken. A map update reads the map entry and, unless the journal is busy, writes it and
// updates the valid-page counts of the old and new block. Free and victim searches and format
// go one block entry per cycle through the single read port of the block tables; open marks
// the target block open and counts an erase, and set state writes its state. A result sits
// in an output register, so a new item may be accepted while it waits; the following result
// is held back until the waiting one is taken.
`default_nettype none

module flash_block_table_manager import fbtm_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [2:0]  mode,
    input  wire logic [11:0] logical_page,
    input  wire logic        new_valid,
    input  wire logic [5:0]  new_block,
    input  wire logic [7:0]  new_page,
    input  wire logic        stream_kind,
    input  wire logic        journal_busy,
    input  wire logic [5:0]  target_block,
    input  wire logic [1:0]  target_state,
    input  wire logic        take_first,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             accepted,
    output logic             found,
    output logic [5:0]       found_block,
    output logic [8:0]       found_count,
    output logic             victim_hit,
    output logic             old_valid,
    output logic [5:0]       old_block,
    output logic [7:0]       old_page
);

`include "flash_block_table_manager_assert.svh"

    dp_op_t op;
    stat_t  stat;

    // sequencer
    fbtm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .op        (op)
    );

    // tables, counters and result register
    fbtm_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .op           (op),
        .stat         (stat),
        .mode         (mode),
        .logical_page (logical_page),
        .new_valid    (new_valid),
        .new_block    (new_block),
        .new_page     (new_page),
        .stream_kind  (stream_kind),
        .journal_busy (journal_busy),
        .target_block (target_block),
        .target_state (target_state),
        .take_first   (take_first),
        .accepted     (accepted),
        .found        (found),
        .found_block  (found_block),
        .found_count  (found_count),
        .victim_hit   (victim_hit),
        .old_valid    (old_valid),
        .old_block    (old_block),
        .old_page     (old_page)
    );

    // checks
    `FBTM_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "item taken while busy")
    `FBTM_ASSERT_SAME(a_load_free, op == OP_RESULT, !out_valid || out_ready, "result overwritten")
    `FBTM_ASSERT_SAME(a_old_zero, out_valid && !old_valid, old_block == 6'd0 && old_page == 8'd0, "stale old mapping")
    `FBTM_ASSERT_SAME(a_mode_excl, out_valid && found, !accepted && !victim_hit, "search and update mixed")

endmodule

`default_nettype wire
